// File: rtl/core/ilie_pkg.sv
// Shared types and constants for the indexed list with insert and erase.
package ilie_pkg;

   localparam int CAPACITY  = 64;
   localparam int WORD_W    = 32;
   localparam int CMD_W     = 3;
   localparam int POS_W     = 7;
   localparam int FCNT_W    = 7;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_ERASE  = 3'd3,
      CMD_PUSH   = 3'd4,
      CMD_ASSIGN = 3'd5,
      CMD_RESIZE = 3'd6,
      CMD_NONE   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_ERASE,
      CELL_FILL
   } cell_op_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      cell_op_type      op;
      logic [CMP_W-1:0] index;
      logic [CMP_W-1:0] fill_lo;
      logic [CMP_W-1:0] fill_hi;
   } cell_ctl_type;

   // Outcome of one item as seen by the result register.
   typedef struct packed {
      logic [CNT_W-1:0] count_next;
      status_type       status;
      logic             read_ok;
   } ctrl_res_type;

endpackage

// File: rtl/core/ilie_cell.sv
// One element cell of the list row: holds one word and moves it to or from its neighbors.
module ilie_cell import ilie_pkg::*; (
   input  logic             clock,
   input  logic [IDX_W-1:0] cell_index,
   input  cell_ctl_type     ctl,
   input  word_type         word_value,
   input  word_type         left_word,
   input  word_type         right_word,
   output word_type         cell_word
);

   word_type         word_ff;
   word_type         word_in;
   logic [CMP_W-1:0] idx_ext;

   assign idx_ext   = CMP_W'(cell_index);
   assign cell_word = word_ff;

   always_comb begin
      word_in = word_ff;
      case (ctl.op)
         CELL_WRITE: begin
            if (idx_ext == ctl.index) word_in = word_value;
         end
         CELL_INSERT: begin
            // Everything above the insert point moves up by one place.
            if (idx_ext == ctl.index) word_in = word_value;
            else if (idx_ext > ctl.index) word_in = left_word;
         end
         CELL_ERASE: begin
            if (idx_ext >= ctl.index) word_in = right_word;
         end
         CELL_FILL: begin
            if (idx_ext >= ctl.fill_lo && idx_ext < ctl.fill_hi) word_in = word_value;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// File: rtl/core/ilie_ctrl.sv
// Command decode, range and capacity checks, and the element count register.
module ilie_ctrl import ilie_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [CMD_W-1:0]  command,
   input  logic [POS_W-1:0]  position,
   input  logic [FCNT_W-1:0] new_count,
   output cell_ctl_type      ctl,
   output ctrl_res_type      res
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] n_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] cap_ext;
   cell_ctl_type     ctl_dec;

   assign pos_ext = CMP_W'(position);
   assign n_ext   = CMP_W'(new_count);
   assign cnt_ext = CMP_W'(count_ff);
   assign cap_ext = CMP_W'(CAPACITY);

   always_comb begin
      ctl_dec.op      = CELL_HOLD;
      ctl_dec.index   = pos_ext;
      ctl_dec.fill_lo = '0;
      ctl_dec.fill_hi = '0;
      res.count_next  = count_ff;
      res.status      = ST_OK;
      res.read_ok     = 1'b0;
      case (cmd_type'(command))
         CMD_READ: begin
            if (pos_ext < cnt_ext) res.read_ok = 1'b1;
            else res.status = ST_RANGE;
         end
         CMD_WRITE: begin
            if (pos_ext < cnt_ext) ctl_dec.op = CELL_WRITE;
            else res.status = ST_RANGE;
         end
         CMD_INSERT: begin
            // The range check takes precedence over the capacity check.
            if (pos_ext > cnt_ext) begin
               res.status = ST_RANGE;
            end else if (cnt_ext == cap_ext) begin
               res.status = ST_FULL;
            end else begin
               ctl_dec.op     = CELL_INSERT;
               res.count_next = count_ff + CNT_W'(1);
            end
         end
         CMD_ERASE: begin
            if (pos_ext < cnt_ext) begin
               ctl_dec.op     = CELL_ERASE;
               res.count_next = count_ff - CNT_W'(1);
            end else begin
               res.status = ST_RANGE;
            end
         end
         CMD_PUSH: begin
            if (cnt_ext == cap_ext) begin
               res.status = ST_FULL;
            end else begin
               ctl_dec.op     = CELL_WRITE;
               ctl_dec.index  = cnt_ext;
               res.count_next = count_ff + CNT_W'(1);
            end
         end
         CMD_ASSIGN: begin
            if (n_ext > cap_ext) begin
               res.status = ST_FULL;
            end else begin
               ctl_dec.op      = CELL_FILL;
               ctl_dec.fill_hi = n_ext;
               res.count_next  = CNT_W'(n_ext);
            end
         end
         CMD_RESIZE: begin
            // Only the new tail is filled; a shrink just lowers the count.
            if (n_ext > cap_ext) begin
               res.status = ST_FULL;
            end else begin
               ctl_dec.op      = CELL_FILL;
               ctl_dec.fill_lo = cnt_ext;
               ctl_dec.fill_hi = n_ext;
               res.count_next  = CNT_W'(n_ext);
            end
         end
         default: begin
            res.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      ctl = ctl_dec;
      if (!accept) ctl.op = CELL_HOLD;
   end

   assign count_in = accept ? res.count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/indexed_list_insert_erase.sv
// Top level of the fixed-capacity indexed list: cell row, read select and result register.
//
// Usage:
//  The req_ channel carries one command per item: read, write, insert, erase,
//  push, assign or resize, with a position, a word and a target count.
//  The rsp_ channel returns exactly one item per command with the word read,
//  the element count after the command, an empty flag and a status
//  (ok, index out of range, capacity full).
//  The list lives in a row of 64 cells. Every cell updates in the same cycle,
//  loading the new word, taking its lower neighbor (insert) or its upper
//  neighbor (erase), so any command completes in the cycle it is accepted.
//  The result is registered and appears in the cycle after the item is accepted.
//  Throughput: one item per cycle while the receiver takes each result, set by
//  the cell update and the result register in front of rsp_.
//  When the receiver stalls, the result register holds its item and req_tready
//  drops until that item is taken; a new item is accepted in the same cycle
//  that the waiting result leaves.
//  Reset empties the list (count zero) and drops rsp_tvalid; cell contents are
//  left as they are and are never read before being written.
module indexed_list_insert_erase import ilie_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] command, [9:3] position, [41:10] word_value, [48:42] new_count
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] read_word, [38:32] element_count, [39] is_empty, [41:40] status
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic              accept;
   logic [CMD_W-1:0]  command;
   logic [POS_W-1:0]  position;
   word_type          word_value;
   logic [FCNT_W-1:0] new_count;
   cell_ctl_type      ctl;
   ctrl_res_type      res;
   word_type          cell_word [CAPACITY];
   logic [CMP_W-1:0]  pos_ext;
   word_type          read_word;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   assign command    = req_tdata[2:0];
   assign position   = req_tdata[9:3];
   assign word_value = req_tdata[41:10];
   assign new_count  = req_tdata[48:42];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ilie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (command),
      .position  (position),
      .new_count (new_count),
      .ctl       (ctl),
      .res       (res)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type left_word;
      word_type right_word;
      if (i == 0) begin : g_first
         assign left_word = word_value;
      end else begin : g_mid_lo
         assign left_word = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_mid_hi
         assign right_word = cell_word[i+1];
      end
      ilie_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctl        (ctl),
         .word_value (word_value),
         .left_word  (left_word),
         .right_word (right_word),
         .cell_word  (cell_word[i])
      );
   end

   assign pos_ext   = CMP_W'(position);
   assign read_word = res.read_ok ? cell_word[pos_ext[IDX_W-1:0]] : '0;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         rsp_data_in = {6'b0, res.status, (res.count_next == '0),
                        FCNT_W'(res.count_next), read_word};
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/ilie_checker.sv
// Port-level checks for the indexed list, bound to the top level.
module ilie_checker import ilie_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A result that the receiver stalls stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // The empty flag agrees with the element count.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39] == (rsp_tdata[38:32] == '0)))
      else $error("empty flag disagrees with element count");

   // The count never passes the capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[38:32]) <= 32'(CAPACITY)))
      else $error("element count above capacity");

   // A failed command returns no word.
   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[41:40] != ST_OK) |-> (rsp_tdata[31:0] == '0))
      else $error("failed command returned a word");

   // Only a read may return a nonzero word, in the cycle after acceptance.
   a_read_only: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[2:0] != CMD_READ)
      |=> rsp_tvalid && (rsp_tdata[31:0] == '0))
      else $error("non-read command returned a word");

endmodule

bind indexed_list_insert_erase ilie_checker u_ilie_checker (.*);
